FILE: rtl/core/ede_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance engine package
// Shared sizes, command codes, item types and the ASCII case fold.
// ----------------------------------------------------------------------------
package ede_pkg;

  localparam int MAX_LEN = 64;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CODE_W  = 16;
  localparam int CMD_W   = 2;
  localparam int DIST_W  = 7;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;

  localparam logic [CODE_W-1:0] ASCII_UPPER_A  = 16'h0041;
  localparam logic [CODE_W-1:0] ASCII_UPPER_Z  = 16'h005A;
  localparam logic [CODE_W-1:0] ASCII_CASE_OFS = 16'h0020;

  typedef enum logic [1:0] {
    OP_APPEND_A,
    OP_APPEND_B,
    OP_COMPUTE
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CODE_W-1:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflowed;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

  function automatic logic [CODE_W-1:0] fold_code(input logic [CODE_W-1:0] c,
                                                  input logic cs);
    logic [CODE_W-1:0] r;
    r = c;
    if (!cs && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      r = c + ASCII_CASE_OFS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ede_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance engine front end
// Accepts input items, decodes the command and pushes work into the queue.
// ----------------------------------------------------------------------------
module ede_front (
  input  wire logic              in_valid,
  input  wire ede_pkg::in_item_t in_item,
  output      logic              in_stall,
  input  wire logic              q_full,
  output      ede_pkg::q_port_t  push
);
  import ede_pkg::*;

  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    push.valid      = 1'b0;
    push.entry.op   = OP_APPEND_A;
    push.entry.code = in_item.char_code;
    unique case (in_item.command)
      CMD_APPEND_A: begin
        push.valid    = accept;
        push.entry.op = OP_APPEND_A;
      end
      CMD_APPEND_B: begin
        push.valid    = accept;
        push.entry.op = OP_APPEND_B;
      end
      CMD_COMPUTE: begin
        push.valid    = accept;
        push.entry.op = OP_COMPUTE;
      end
      // undefined command: take the item, drop it
      default: begin
        push.valid = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/ede_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance engine work queue
// Small FIFO of decoded items between the front end and the back end.
// ----------------------------------------------------------------------------
module ede_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ede_pkg::q_port_t push,
  output      logic             full,
  output      ede_pkg::q_port_t head,
  input  wire logic             pop
);
  import ede_pkg::*;

  q_entry_t            entries_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.entry = entries_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    priority if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ede_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance engine back end
// Holds both strings, runs the row-buffer dynamic program one cell per
// cycle within each row and drives the result register.
// ----------------------------------------------------------------------------
module ede_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              case_sensitive,
  input  wire ede_pkg::q_port_t  q_head,
  output      logic              q_pop,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      ede_pkg::out_item_t out_item
);
  import ede_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROW  = 4'b0010,
    ST_CELL = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_a_r, len_a_nxt;
  logic [LEN_W-1:0]  len_b_r, len_b_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [LEN_W-1:0]  diag_r, diag_nxt;
  logic [LEN_W-1:0]  res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // string and row storage
  logic [CODE_W-1:0] str_a_mem [MAX_LEN];
  logic [CODE_W-1:0] str_b_mem [MAX_LEN];
  logic [LEN_W-1:0]  row_mem   [MAX_LEN + 1];
  logic [CODE_W-1:0] a_q_r, b_q_r;
  logic [LEN_W-1:0]  row_q_r;

  logic              a_we, b_we, a_re, b_re, row_we, row_re;
  logic [ADDR_W-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [LEN_W-1:0]  row_waddr, row_raddr, row_wdata;

  // cell update
  logic [LEN_W-1:0]  above;
  logic              cost;
  logic [LEN_W:0]    cand_left, cand_above, cand_diag, cand_min;
  logic [LEN_W-1:0]  cell_val;
  logic [LEN_W-1:0]  j_next_len;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    above      = (i_r == '0) ? LEN_W'(j_r) + LEN_W'(1) : row_q_r;
    cost       = (fold_code(a_q_r, case_sensitive) != fold_code(b_q_r, case_sensitive));
    cand_left  = {1'b0, left_r} + (LEN_W+1)'(1);
    cand_above = {1'b0, above} + (LEN_W+1)'(1);
    cand_diag  = {1'b0, diag_r} + (LEN_W+1)'(cost);
    cand_min   = (cand_left < cand_above) ? cand_left : cand_above;
    cand_min   = (cand_diag < cand_min) ? cand_diag : cand_min;
    cell_val   = cand_min[LEN_W-1:0];
    j_next_len = LEN_W'(j_r) + LEN_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    len_a_nxt     = len_a_r;
    len_b_nxt     = len_b_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    res_nxt       = res_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    a_we          = 1'b0;
    b_we          = 1'b0;
    a_re          = 1'b0;
    b_re          = 1'b0;
    row_we        = 1'b0;
    row_re        = 1'b0;
    a_waddr       = len_a_r[ADDR_W-1:0];
    b_waddr       = len_b_r[ADDR_W-1:0];
    a_raddr       = i_r;
    b_raddr       = '0;
    row_raddr     = LEN_W'(1);
    row_waddr     = j_next_len;
    row_wdata     = cell_val;

    unique case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          unique case (q_head.entry.op)
            OP_APPEND_A: begin
              if (len_a_r < LEN_W'(MAX_LEN)) begin
                a_we      = 1'b1;
                len_a_nxt = len_a_r + LEN_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_APPEND_B: begin
              if (len_b_r < LEN_W'(MAX_LEN)) begin
                b_we      = 1'b1;
                len_b_nxt = len_b_r + LEN_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_COMPUTE: begin
              priority if (len_a_r == '0) begin
                res_nxt   = len_b_r;
                state_nxt = ST_OUT;
              end else if (len_b_r == '0) begin
                res_nxt   = len_a_r;
                state_nxt = ST_OUT;
              end else begin
                i_nxt     = '0;
                state_nxt = ST_ROW;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end

      // fetch the row's A code and the first B code and row entry
      ST_ROW: begin
        a_re      = 1'b1;
        b_re      = 1'b1;
        row_re    = 1'b1;
        j_nxt     = '0;
        left_nxt  = LEN_W'(i_r) + LEN_W'(1);
        diag_nxt  = LEN_W'(i_r);
        state_nxt = ST_CELL;
      end

      ST_CELL: begin
        row_we   = 1'b1;
        left_nxt = cell_val;
        diag_nxt = above;
        priority if (j_next_len < len_b_r) begin
          j_nxt     = j_r + ADDR_W'(1);
          b_re      = 1'b1;
          b_raddr   = j_r + ADDR_W'(1);
          row_re    = 1'b1;
          row_raddr = j_next_len + LEN_W'(1);
        end else if ((LEN_W'(i_r) + LEN_W'(1)) < len_a_r) begin
          i_nxt     = i_r + ADDR_W'(1);
          state_nxt = ST_ROW;
        end else begin
          res_nxt   = cell_val;
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.distance   = DIST_W'(res_r);
          out_item_nxt.overflowed = ovf_r;
          len_a_nxt               = '0;
          len_b_nxt               = '0;
          ovf_nxt                 = 1'b0;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      str_a_mem[a_waddr] <= q_head.entry.code;
    end
    if (a_re) begin
      a_q_r <= str_a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      str_b_mem[b_waddr] <= q_head.entry.code;
    end
    if (b_re) begin
      b_q_r <= str_b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_q_r <= row_mem[row_raddr];
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    left_r     <= left_nxt;
    diag_r     <= diag_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_a_r     <= '0;
      len_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/edit_distance_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance engine core
// Loads two strings of 16-bit codes and returns their Levenshtein distance.
//
//   Channel  Signals                      Direction  Carries
//   in       in_valid/in_stall/in_item    input      command + char_code
//   out      out_valid/out_stall/out_item output     distance + overflowed
//   cfg      cfg_we/cfg_wdata             input      case_sensitive
//
// Appends retire one per cycle, while the back end is idle, through a
// four-entry work queue. A compute runs in the back end one cell per cycle
// within each row, through the shared cell update and the single-read row
// buffer; an empty string skips straight to the result.
// Synchronous active-low reset clears lengths, overflow, queue, out_valid.
// in_stall rises when the queue is full; out_stall holds result and back end.
// ----------------------------------------------------------------------------
module edit_distance_engine_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire ede_pkg::in_item_t  in_item,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      ede_pkg::out_item_t out_item
);
  import ede_pkg::*;

  logic    case_sensitive_r, case_sensitive_nxt;
  q_port_t fe_push;
  q_port_t q_head;
  logic    q_full;
  logic    q_pop;

  assign case_sensitive_nxt = cfg_we ? cfg_wdata : case_sensitive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_sensitive_r <= 1'b1;
    end else begin
      case_sensitive_r <= case_sensitive_nxt;
    end
  end

  ede_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (fe_push)
  );

  ede_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  ede_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .case_sensitive (case_sensitive_r),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("back end popped an empty queue");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    fe_push.valid |-> !q_full)
    else $error("front end pushed into a full queue");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
